FILE: rtl/lcdp_pkg.sv
// ----------------------------------------------------------------------------
// Line command duty parser package
// Shared types and constants for the line command duty parser.
// ----------------------------------------------------------------------------
package lcdp_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int DUTY_WIDTH   = 10;
   localparam int LENGTH_WIDTH = 8;
   localparam int KEY_WIDTH    = 4;
   localparam int DIGIT_WIDTH  = 2;

   localparam logic [BYTE_WIDTH-1:0]   CH_CR   = 8'h0D;
   localparam logic [BYTE_WIDTH-1:0]   CH_LF   = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0]   CH_ZERO = 8'd48;
   localparam logic [BYTE_WIDTH-1:0]   CH_NINE = 8'd57;
   localparam logic [KEY_WIDTH-1:0]    KEY_LEN = 4'd8;
   localparam logic [DIGIT_WIDTH-1:0]  DIGIT_COUNT = 2'd3;
   localparam logic [DUTY_WIDTH-1:0]   DUTY_LIMIT_RESET = 10'd100;

   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [DUTY_WIDTH-1:0] duty_type;

   typedef struct packed {
      logic     duty_write;
      duty_type duty_value;
      logic     command_error;
      logic     line_complete;
   } result_type;

   // Characters of the command keyword T1C1PWM_.
   function automatic byte_type key_char(input logic [KEY_WIDTH-2:0] position);
      byte_type ch;
      case (position)
         3'd0:    ch = 8'h54;
         3'd1:    ch = 8'h31;
         3'd2:    ch = 8'h43;
         3'd3:    ch = 8'h31;
         3'd4:    ch = 8'h50;
         3'd5:    ch = 8'h57;
         3'd6:    ch = 8'h4D;
         3'd7:    ch = 8'h5F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/lcdp_input_stage.sv
// ----------------------------------------------------------------------------
// Line command duty parser input stage
// Registers each accepted byte and holds it until the line engine takes it.
// ----------------------------------------------------------------------------
module lcdp_input_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lcdp_pkg::byte_type req_rx_byte,
   input  logic               advance,
   output logic               byte_valid,
   output lcdp_pkg::byte_type rx_byte
);

   logic               valid_ff;
   logic               valid_in;
   lcdp_pkg::byte_type byte_ff;
   logic               load;

   assign req_stall  = valid_ff & ~advance;
   assign load       = req_valid & ~req_stall;
   assign valid_in   = load | (valid_ff & ~advance);
   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

FILE: rtl/lcdp_line_engine.sv
// ----------------------------------------------------------------------------
// Line command duty parser line engine
// Holds the line framing and keyword state and computes one result per byte.
// ----------------------------------------------------------------------------
module lcdp_line_engine #(
   parameter int LINE_LEN = 200
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  lcdp_pkg::byte_type   rx_byte,
   input  lcdp_pkg::duty_type   duty_limit,
   output lcdp_pkg::result_type result
);

   logic                                cr_seen_ff, cr_seen_in;
   logic [lcdp_pkg::LENGTH_WIDTH-1:0]   length_ff, length_in;
   logic [lcdp_pkg::KEY_WIDTH-1:0]      progress_ff, progress_in;
   logic [lcdp_pkg::DIGIT_WIDTH-1:0]    digits_ff, digits_in;
   lcdp_pkg::duty_type                  acc_ff, acc_in;
   logic                                found_ff, found_in;
   logic                                fault_ff, fault_in;

   logic [lcdp_pkg::LENGTH_WIDTH:0]     length_sum;
   logic [lcdp_pkg::DUTY_WIDTH+3:0]     acc_next;
   logic                                is_digit;
   logic                                command_ok;

   assign length_sum = {1'b0, length_ff} + 9'd1;
   assign is_digit   = (rx_byte >= lcdp_pkg::CH_ZERO) && (rx_byte <= lcdp_pkg::CH_NINE);
   assign acc_next   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                       + {10'd0, rx_byte[3:0]};
   assign command_ok = (digits_ff == lcdp_pkg::DIGIT_COUNT) && !fault_ff
                       && (acc_ff <= duty_limit);

   always_comb begin
      result = '0;
      if (cr_seen_ff && (rx_byte == lcdp_pkg::CH_LF)) begin
         result.line_complete = 1'b1;
         if (found_ff) begin
            if (command_ok) begin
               result.duty_write = 1'b1;
               result.duty_value = acc_ff;
            end else begin
               result.command_error = 1'b1;
            end
         end
      end
   end

   always_comb begin
      cr_seen_in  = cr_seen_ff;
      length_in   = length_ff;
      progress_in = progress_ff;
      digits_in   = digits_ff;
      acc_in      = acc_ff;
      found_in    = found_ff;
      fault_in    = fault_ff;
      if (advance) begin
         if (cr_seen_ff) begin
            cr_seen_in  = 1'b0;
            length_in   = '0;
            progress_in = '0;
            digits_in   = '0;
            acc_in      = '0;
            found_in    = 1'b0;
            fault_in    = 1'b0;
         end else if (rx_byte == lcdp_pkg::CH_CR) begin
            cr_seen_in = 1'b1;
         end else begin
            if (found_ff) begin
               if (digits_ff < lcdp_pkg::DIGIT_COUNT) begin
                  if (is_digit) begin
                     acc_in = acc_next[lcdp_pkg::DUTY_WIDTH-1:0];
                  end else begin
                     fault_in = 1'b1;
                  end
                  digits_in = digits_ff + 2'd1;
               end
            end else begin
               if ((progress_ff < lcdp_pkg::KEY_LEN)
                   && (rx_byte == lcdp_pkg::key_char(progress_ff[2:0]))) begin
                  progress_in = progress_ff + 4'd1;
               end else if (rx_byte == lcdp_pkg::key_char(3'd0)) begin
                  progress_in = 4'd1;
               end else begin
                  progress_in = '0;
               end
               if (progress_in >= lcdp_pkg::KEY_LEN) begin
                  found_in = 1'b1;
               end
            end
            length_in = length_sum[lcdp_pkg::LENGTH_WIDTH-1:0];
            if (length_sum >= 9'(LINE_LEN)) begin
               length_in   = '0;
               progress_in = '0;
               digits_in   = '0;
               acc_in      = '0;
               found_in    = 1'b0;
               fault_in    = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_seen_ff  <= 1'b0;
         length_ff   <= '0;
         progress_ff <= '0;
         digits_ff   <= '0;
         acc_ff      <= '0;
         found_ff    <= 1'b0;
         fault_ff    <= 1'b0;
      end else begin
         cr_seen_ff  <= cr_seen_in;
         length_ff   <= length_in;
         progress_ff <= progress_in;
         digits_ff   <= digits_in;
         acc_ff      <= acc_in;
         found_ff    <= found_in;
         fault_ff    <= fault_in;
      end
   end

endmodule

FILE: rtl/lcdp_output_stage.sv
// ----------------------------------------------------------------------------
// Line command duty parser output stage
// Result register that holds a transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module lcdp_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  lcdp_pkg::result_type result,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lcdp_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   lcdp_pkg::result_type result_ff;

   assign advance    = byte_valid & (~valid_ff | ~rsp_stall);
   assign valid_in   = advance | (valid_ff & rsp_stall);
   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

endmodule

FILE: rtl/line_command_duty_parser.sv
// ----------------------------------------------------------------------------
// Line command duty parser
// Each accepted byte passes from the input register through the line engine into the result register.
// Throughput: one byte per cycle while rsp_stall is low, one result transaction per byte.
// The rate is set by the combinational line engine update between the
// input register and the result register.
// Reset clears all line state and sets the duty limit to 100.
// ----------------------------------------------------------------------------
module line_command_duty_parser #(
   parameter int LINE_LEN = 200
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lcdp_pkg::byte_type req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_duty_write,
   output lcdp_pkg::duty_type rsp_duty_value,
   output logic               rsp_command_error,
   output logic               rsp_line_complete,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  lcdp_pkg::duty_type csr_duty_limit
);

   lcdp_pkg::duty_type   duty_limit_ff;
   logic                 advance;
   logic                 byte_valid;
   lcdp_pkg::byte_type   rx_byte;
   lcdp_pkg::result_type result;
   lcdp_pkg::result_type rsp_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_limit_ff <= lcdp_pkg::DUTY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         duty_limit_ff <= csr_duty_limit;
      end
   end

   lcdp_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .rx_byte     (rx_byte)
   );

   lcdp_line_engine #(
      .LINE_LEN (LINE_LEN)
   ) u_line_engine (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .rx_byte    (rx_byte),
      .duty_limit (duty_limit_ff),
      .result     (result)
   );

   lcdp_output_stage u_output_stage (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .result     (result),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_duty_write    = rsp_result.duty_write;
   assign rsp_duty_value    = rsp_result.duty_value;
   assign rsp_command_error = rsp_result.command_error;
   assign rsp_line_complete = rsp_result.line_complete;

endmodule
